@@ rtl/core/text_console_char_writer_defines.svh @@
// ----------------------------------------------------------------------------
// text_console_char_writer_defines: assertion macros
// Same-cycle and next-cycle implication checks on i_clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CHAR_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_CHAR_WRITER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define TCW_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TCW_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`else

`define TCW_ASSERT_IMP(label, ante, cons, msg)
`define TCW_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

@@ rtl/core/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// tcw_pkg: shared constants and types of the text console
// Command codes, control characters, reset colors and cell helpers.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int DEF_COLS = 80;
    localparam int DEF_ROWS = 25;

    localparam int CMD_W   = 2;
    localparam int CHAR_W  = 8;
    localparam int COLOR_W = 4;
    localparam int CELL_W  = 16;

    typedef logic [CELL_W-1:0]  t_cell;
    typedef logic [COLOR_W-1:0] t_color;
    typedef logic [CHAR_W-1:0]  t_char;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // control characters
    localparam t_char CH_BS    = 8'd8;
    localparam t_char CH_TAB   = 8'd9;
    localparam t_char CH_NL    = 8'd10;
    localparam t_char CH_CR    = 8'd13;
    localparam t_char CH_SPACE = 8'd32;

    localparam int TAB_STEP = 4;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_FG = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BG = 1'd1;

    localparam t_color RST_FG = 4'd9;
    localparam t_color RST_BG = 4'd0;

    // attribute high byte, character low byte
    function automatic t_cell make_cell(input t_color fg, input t_color bg, input t_char ch);
        make_cell = {bg, fg, ch};
    endfunction

endpackage

@@ rtl/core/text_console_char_writer.sv @@
// ----------------------------------------------------------------------------
// text_console_char_writer: character-cell console with cursor
// printable, tab, cr/nl without scroll and unused codes raise o_strobe straight from idle;
// backspace and read pass through S_BS2 or S_READ; scroll and clear sweep every cell first
// the commands that strobe from idle can follow back to back; after the others a new
// command is taken once busy drops
// after reset the writer is busy while a sweep blanks the screen; start is not taken
// ----------------------------------------------------------------------------
`include "text_console_char_writer_defines.svh"

module text_console_char_writer
    import tcw_pkg::*;
#(
    parameter  int COLS  = DEF_COLS,
    parameter  int ROWS  = DEF_ROWS,
    localparam int CELLS = ROWS * COLS,
    localparam int COL_W = $clog2(COLS),
    localparam int ROW_W = $clog2(ROWS),
    localparam int IDX_W = $clog2(CELLS)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COLOR_W-1:0]   i_cfg_data,

    // command side
    input  logic                 start,
    output logic                 busy,
    input  logic [CMD_W-1:0]     i_cmd,
    input  logic [CHAR_W-1:0]    i_char_code,
    input  logic [IDX_W-1:0]     i_cell_index,

    // result side, one strobe per command, no back-pressure
    output logic                 o_strobe,
    output logic [ROW_W-1:0]     o_row_now,
    output logic [COL_W-1:0]     o_column_now,
    output logic [CELL_W-1:0]    o_cell_data
);

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_INIT   = 3'd1;  // reset sweep, no result
    localparam logic [2:0] S_FILL   = 3'd2;  // clear sweep
    localparam logic [2:0] S_SHIFT  = 3'd3;  // scroll copy, one cell per cycle
    localparam logic [2:0] S_SH_END = 3'd4;  // last scroll write drains
    localparam logic [2:0] S_BS2    = 3'd5;  // second backspace write
    localparam logic [2:0] S_READ   = 3'd6;  // memory read data returns

    localparam logic [IDX_W-1:0] LAST_CELL = IDX_W'(CELLS - 1);

    // screen memory, one write and one registered read per cycle
    t_cell mem [CELLS];

    // configuration registers
    t_color r_fg, r_bg;

    // control and cursor
    logic [2:0]       r_state, n_state;
    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_col, n_col;
    logic [IDX_W-1:0] r_addr, n_addr;       // sweep pointer for fill and scroll
    t_cell            r_fill_word, n_fill_word;
    logic             r_strobe, n_strobe;
    t_cell            r_cell_data, n_cell_data;
    logic             r_rd_ok, n_rd_ok;

    // scroll write stage: the cell read last cycle lands COLS cells lower
    logic             r_sh_v;
    logic             r_sh_copy;
    logic [IDX_W-1:0] r_sh_addr;

    // memory port controls
    logic             mem_we, mem_re;
    logic [IDX_W-1:0] mem_wa, mem_ra;
    t_cell            mem_wd;
    t_cell            r_rdata;

    // derived values
    logic [IDX_W-1:0] cur_lin;
    logic [IDX_W:0]   sh_src;
    logic             sh_in;
    logic [COL_W:0]   col_inc, col_tab;
    logic             last_row;
    logic [ROW_W-1:0] row_wrap;
    t_cell            blank;
    logic             accept;
    logic             rd_in_range;

    assign accept      = start && !busy;
    assign blank       = make_cell(r_fg, r_bg, CH_SPACE);
    assign cur_lin     = IDX_W'(r_row * COLS + r_col);
    assign sh_src      = {1'b0, r_addr} + (IDX_W+1)'(COLS);
    assign sh_in       = sh_src < (IDX_W+1)'(CELLS);
    assign col_inc     = {1'b0, r_col} + (COL_W+1)'(1);
    assign col_tab     = {1'b0, r_col} + (COL_W+1)'(TAB_STEP);
    assign last_row    = r_row == ROW_W'(ROWS - 1);
    // line wrap for printable and tab goes back to row 0 without scrolling
    assign row_wrap    = last_row ? '0 : r_row + ROW_W'(1);
    assign rd_in_range = {1'b0, i_cell_index} < (IDX_W+1)'(CELLS);

    // configuration writes, only while idle by contract
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= RST_FG;
            r_bg <= RST_BG;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FG:  r_fg <= i_cfg_data;
                CFG_BG:  r_bg <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer and memory port steering
    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_col       = r_col;
        n_addr      = r_addr;
        n_fill_word = r_fill_word;
        n_strobe    = 1'b0;
        n_cell_data = r_cell_data;
        n_rd_ok     = r_rd_ok;

        mem_we = 1'b0;
        mem_wa = cur_lin;
        mem_wd = blank;
        mem_re = 1'b0;
        mem_ra = i_cell_index;

        // scroll write stage owns the write port while it runs
        if (r_sh_v) begin
            mem_we = 1'b1;
            mem_wa = r_sh_addr;
            mem_wd = r_sh_copy ? r_rdata : blank;
        end

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cell_data = '0;
                    case (i_cmd)
                        CMD_PUT: begin
                            if (i_char_code inside {CH_NL, CH_CR}) begin
                                n_col = '0;
                                if (last_row) begin
                                    // bottom line: scroll, cursor stays on last row
                                    n_state = S_SHIFT;
                                    n_addr  = '0;
                                end else begin
                                    n_row    = r_row + ROW_W'(1);
                                    n_strobe = 1'b1;
                                end
                            end else if (i_char_code == CH_TAB) begin
                                if (col_tab >= (COL_W+1)'(COLS)) begin
                                    n_col = '0;
                                    n_row = row_wrap;
                                end else begin
                                    n_col = col_tab[COL_W-1:0];
                                end
                                n_strobe = 1'b1;
                            end else if (i_char_code == CH_BS) begin
                                // blank under the cursor now, the left cell next cycle
                                mem_we  = 1'b1;
                                if (r_col != '0) begin
                                    n_col = r_col - COL_W'(1);
                                end
                                n_state = S_BS2;
                            end else begin
                                mem_we = 1'b1;
                                mem_wd = make_cell(r_fg, r_bg, i_char_code);
                                if (col_inc >= (COL_W+1)'(COLS)) begin
                                    n_col = '0;
                                    n_row = row_wrap;
                                end else begin
                                    n_col = col_inc[COL_W-1:0];
                                end
                                n_strobe = 1'b1;
                            end
                        end
                        CMD_READ: begin
                            mem_re  = rd_in_range;
                            n_rd_ok = rd_in_range;
                            n_state = S_READ;
                        end
                        CMD_CLEAR: begin
                            n_state     = S_FILL;
                            n_addr      = '0;
                            n_fill_word = blank;
                            n_row       = '0;
                            n_col       = '0;
                        end
                        default: begin
                            n_strobe = 1'b1;
                        end
                    endcase
                end
            end
            S_INIT, S_FILL: begin
                mem_we = 1'b1;
                mem_wa = r_addr;
                mem_wd = r_fill_word;
                if (r_addr == LAST_CELL) begin
                    n_state  = S_IDLE;
                    n_strobe = (r_state == S_FILL);
                end else begin
                    n_addr = r_addr + IDX_W'(1);
                end
            end
            S_SHIFT: begin
                // read one row ahead; cells of the last row get blanks
                mem_re = sh_in;
                mem_ra = sh_src[IDX_W-1:0];
                if (r_addr == LAST_CELL) begin
                    n_state = S_SH_END;
                end else begin
                    n_addr = r_addr + IDX_W'(1);
                end
            end
            S_SH_END: begin
                n_state  = S_IDLE;
                n_strobe = 1'b1;
            end
            S_BS2: begin
                // cursor already stepped back; at column 0 this rewrites the same blank
                mem_we   = 1'b1;
                n_state  = S_IDLE;
                n_strobe = 1'b1;
            end
            S_READ: begin
                n_cell_data = r_rd_ok ? r_rdata : '0;
                n_state     = S_IDLE;
                n_strobe    = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_addr      <= '0;
            r_fill_word <= make_cell(RST_FG, RST_BG, CH_SPACE);
            r_row       <= '0;
            r_col       <= '0;
            r_strobe    <= 1'b0;
            r_sh_v      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_fill_word <= n_fill_word;
            r_row       <= n_row;
            r_col       <= n_col;
            r_strobe    <= n_strobe;
            r_sh_v      <= (r_state == S_SHIFT);
        end
    end

    // result and scroll stage payload
    always_ff @(posedge i_clk) begin
        r_cell_data <= n_cell_data;
        r_rd_ok     <= n_rd_ok;
        r_sh_addr   <= r_addr;
        r_sh_copy   <= sh_in;
    end

    // screen memory; reads run ahead of writes during a scroll, so no entry
    // is read and written in the same cycle and no forwarding is needed
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rdata <= mem[mem_ra];
        end
    end

    assign busy         = (r_state != S_IDLE);
    assign o_strobe     = r_strobe;
    assign o_row_now    = r_row;
    assign o_column_now = r_col;
    assign o_cell_data  = r_cell_data;

    // checks
    `TCW_ASSERT_IMP(a_strobe_idle, o_strobe, !busy, "result strobe while busy")
    `TCW_ASSERT_NXT(a_accept_progress, accept, busy || o_strobe, "accepted command dropped")
    `TCW_ASSERT_IMP(a_cursor_range, 1'b1,
        r_row <= ROW_W'(ROWS - 1) && r_col <= COL_W'(COLS - 1), "cursor out of range")
    `TCW_ASSERT_IMP(a_idle_write, mem_we && !busy, start, "screen write with no command")
    `TCW_ASSERT_IMP(a_scroll_busy, r_sh_v, busy, "scroll write stage active while idle")

endmodule
